// File: rtl/rlts_pkg.sv
// Shared types, constants and helpers for the register list transfer sequencer.
// Used by the front decoder, the request queue, the back sequencer and the top level.
package rlts_pkg;

  localparam int unsigned ADDR_BITS_DEFAULT = 24;
  localparam int unsigned ADDR_FIELD_W      = 24;
  localparam int unsigned MASK_W            = 16;
  localparam int unsigned REG_IDX_W         = 4;
  localparam int unsigned BASE_REG_W        = 3;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned STEP_LONG         = 4;
  localparam int unsigned STEP_WORD         = 2;

  localparam logic KIND_TRANSFER = 1'b0;
  localparam logic KIND_FINISH   = 1'b1;

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_POSTINC = 2'd1,
    MODE_PREDEC  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MASK_W-1:0]     mask;
    logic                  pre;
    logic                  is_long;
    logic                  to_mem;
    logic                  sext;
    logic                  wb_en;
    logic [BASE_REG_W-1:0] wb_reg;
  } rlts_cmd_t;

  typedef struct packed {
    logic                  kind;
    logic [REG_IDX_W-1:0]  reg_index;
    logic                  to_mem;
    logic                  long_size;
    logic                  sext;
    logic                  wb_en;
    logic [BASE_REG_W-1:0] wb_reg;
    logic                  last;
  } rlts_out_t;

  function automatic logic [REG_IDX_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
    logic [REG_IDX_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = REG_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/rlts_front.sv
// Front decoder: classifies one move-multiple request into a command descriptor.
// Depends on rlts_pkg for the descriptor type and the mode codes.
module rlts_front
  import rlts_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic [MASK_W-1:0]       mask_i,
  input  logic                    is_long_i,
  input  logic                    to_regs_i,
  input  logic [1:0]              mode_i,
  input  logic [BASE_REG_W-1:0]   base_reg_i,
  input  logic [ADDR_FIELD_W-1:0] base_address_i,
  output rlts_cmd_t               cmd_o,
  output logic [ADDR_BITS-1:0]    addr_o
);

  logic        pre;
  logic        post;
  logic [31:0] base_ext;

  always_comb begin
    pre            = (mode_i == MODE_PREDEC);
    post           = (mode_i == MODE_POSTINC);
    base_ext       = 32'(base_address_i);
    cmd_o.mask     = mask_i;
    cmd_o.pre      = pre;
    cmd_o.is_long  = is_long_i;
    cmd_o.to_mem   = pre | ~to_regs_i;
    cmd_o.sext     = ~pre & to_regs_i & ~is_long_i;
    cmd_o.wb_en    = pre | post;
    cmd_o.wb_reg   = base_reg_i;
    addr_o         = base_ext[ADDR_BITS-1:0];
  end

endmodule

// File: rtl/rlts_queue.sv
// Short request queue between the front decoder and the back sequencer.
// Depends on rlts_pkg for the descriptor type and the queue depth.
module rlts_queue
  import rlts_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rlts_cmd_t            cmd_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output rlts_cmd_t            cmd_o,
  output logic [ADDR_BITS-1:0] addr_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  rlts_cmd_t            cmd_mem  [QUEUE_DEPTH];
  logic [ADDR_BITS-1:0] addr_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0]     wr_ptr_q;
  logic [IDX_W-1:0]     rd_ptr_q;
  logic [CNT_W-1:0]     count_q;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    full_o  = (count_q == FULL_CNT);
    valid_o = (count_q != '0);
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    cmd_o   = cmd_mem[rd_ptr_q];
    addr_o  = addr_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_mem[wr_ptr_q]  <= cmd_i;
      addr_mem[wr_ptr_q] <= addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/rlts_back.sv
// Back sequencer: walks the register mask of one queued command, one item per cycle
// while unstalled, then the finish item. Depends on rlts_pkg for types and helpers.
module rlts_back
  import rlts_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  rlts_cmd_t            q_cmd_i,
  input  logic [ADDR_BITS-1:0] q_addr_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rlts_out_t            out_o,
  output logic [ADDR_BITS-1:0] out_addr_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam logic [ADDR_BITS-1:0] STEP_L = ADDR_BITS'(STEP_LONG);
  localparam logic [ADDR_BITS-1:0] STEP_W = ADDR_BITS'(STEP_WORD);

  state_e               state_q;
  rlts_cmd_t            cmd_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 out_valid_q;
  rlts_out_t            out_q;
  logic [ADDR_BITS-1:0] out_addr_q;

  logic [REG_IDX_W-1:0] bit_idx;
  logic [ADDR_BITS-1:0] step;
  logic [ADDR_BITS-1:0] next_addr;
  logic                 advance;

  always_comb begin
    bit_idx   = lowest_set(cmd_q.mask);
    step      = cmd_q.is_long ? STEP_L : STEP_W;
    next_addr = cmd_q.pre ? (addr_q - step) : (addr_q + step);
    advance   = !out_valid_q || !out_stall_i;
    q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_addr_o  = out_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_addr_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cmd_q   <= q_cmd_i;
            addr_q  <= q_addr_i;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance) begin
            out_valid_q <= 1'b1;
            if (cmd_q.mask != '0) begin
              out_q.kind      <= KIND_TRANSFER;
              out_q.reg_index <= cmd_q.pre ? ~bit_idx : bit_idx;
              out_q.to_mem    <= cmd_q.to_mem;
              out_q.long_size <= cmd_q.is_long;
              out_q.sext      <= cmd_q.sext;
              out_q.wb_en     <= 1'b0;
              out_q.wb_reg    <= '0;
              out_q.last      <= 1'b0;
              out_addr_q      <= cmd_q.pre ? next_addr : addr_q;
              cmd_q.mask      <= cmd_q.mask & (cmd_q.mask - MASK_W'(1));
              addr_q          <= next_addr;
            end else begin
              out_q.kind      <= KIND_FINISH;
              out_q.reg_index <= '0;
              out_q.to_mem    <= 1'b0;
              out_q.long_size <= 1'b0;
              out_q.sext      <= 1'b0;
              out_q.wb_en     <= cmd_q.wb_en;
              out_q.wb_reg    <= cmd_q.wb_reg;
              out_q.last      <= 1'b1;
              out_addr_q      <= addr_q;
              state_q         <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/register_list_transfer_sequencer_top.sv
// Top level of the register list transfer sequencer.
// Depends on rlts_pkg, rlts_front, rlts_queue and rlts_back.
//
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i/in_stall_o   mask, is_long, to_regs, mode, base_reg,
//                                              base_address
// result    out        out_valid_o/out_stall_i kind, address, reg_index, to_memory,
//                                              long_size, sign_extend, writeback_enable,
//                                              writeback_reg, last
//
// A request with n set mask bits yields n transfer items and one finish item.
// The back sequencer loads a request and then issues its result items in turn while
// the output is not stalled; it loads the next request only after the finish item.
// A two-entry queue holds waiting requests; the input stalls only when it is full.
// Reset empties the queue and the output register; nothing else is kept.
module register_list_transfer_sequencer_top
  import rlts_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [MASK_W-1:0]       mask_i,
  input  logic                    is_long_i,
  input  logic                    to_regs_i,
  input  logic [1:0]              mode_i,
  input  logic [BASE_REG_W-1:0]   base_reg_i,
  input  logic [ADDR_FIELD_W-1:0] base_address_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    kind_o,
  output logic [ADDR_FIELD_W-1:0] address_o,
  output logic [REG_IDX_W-1:0]    reg_index_o,
  output logic                    to_memory_o,
  output logic                    long_size_o,
  output logic                    sign_extend_o,
  output logic                    writeback_enable_o,
  output logic [BASE_REG_W-1:0]   writeback_reg_o,
  output logic                    last_o
);

  rlts_cmd_t            front_cmd;
  logic [ADDR_BITS-1:0] front_addr;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  rlts_cmd_t            q_cmd;
  logic [ADDR_BITS-1:0] q_addr;
  rlts_out_t            out_item;
  logic [ADDR_BITS-1:0] out_addr;
  logic [31:0]          out_addr_ext;

  rlts_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .mask_i        (mask_i),
    .is_long_i     (is_long_i),
    .to_regs_i     (to_regs_i),
    .mode_i        (mode_i),
    .base_reg_i    (base_reg_i),
    .base_address_i(base_address_i),
    .cmd_o         (front_cmd),
    .addr_o        (front_addr)
  );

  rlts_queue #(
    .ADDR_BITS(ADDR_BITS)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .cmd_i  (front_cmd),
    .addr_i (front_addr),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd),
    .addr_o (q_addr)
  );

  rlts_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_addr_i   (q_addr),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_item),
    .out_addr_o (out_addr)
  );

  always_comb begin
    in_stall_o         = q_full;
    out_addr_ext       = 32'(out_addr);
    kind_o             = out_item.kind;
    address_o          = out_addr_ext[ADDR_FIELD_W-1:0];
    reg_index_o        = out_item.reg_index;
    to_memory_o        = out_item.to_mem;
    long_size_o        = out_item.long_size;
    sign_extend_o      = out_item.sext;
    writeback_enable_o = out_item.wb_en;
    writeback_reg_o    = out_item.wb_reg;
    last_o             = out_item.last;
  end

  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> q_valid)
    else $error("accepted request did not reach the queue");

  a_finish_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_FINISH) |-> (last_o && !to_memory_o && !sign_extend_o))
    else $error("finish item carries transfer fields");

  a_transfer_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_TRANSFER) |-> (!last_o && !writeback_enable_o))
    else $error("transfer item carries finish fields");

  a_sext_load_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sign_extend_o) |-> (!to_memory_o && !long_size_o))
    else $error("sign extension on a store or long access");

endmodule

// File: dv/register_list_transfer_sequencer_top_tb.sv
// Self-checking testbench for register_list_transfer_sequencer_top.
// Move-multiple requests are expanded here into the expected transfer and finish items.
// Depends on rlts_pkg and the RTL of the block.
module register_list_transfer_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlts_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_REQUESTS = 100;

  typedef struct {
    logic [MASK_W-1:0]       mask;
    logic                    is_long;
    logic                    to_regs;
    logic [1:0]              mode;
    logic [BASE_REG_W-1:0]   base_reg;
    logic [ADDR_FIELD_W-1:0] base_address;
    bit                      drain_first;
  } move_request_t;

  typedef struct {
    logic                    kind;
    logic [ADDR_FIELD_W-1:0] address;
    logic [REG_IDX_W-1:0]    reg_index;
    logic                    to_memory;
    logic                    long_size;
    logic                    sign_extend;
    logic                    writeback_enable;
    logic [BASE_REG_W-1:0]   writeback_reg;
    logic                    last;
  } transfer_item_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [MASK_W-1:0]       mask_i = '0;
  logic                    is_long_i = 1'b0;
  logic                    to_regs_i = 1'b0;
  logic [1:0]              mode_i = MODE_CONTROL;
  logic [BASE_REG_W-1:0]   base_reg_i = '0;
  logic [ADDR_FIELD_W-1:0] base_address_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    kind_o;
  logic [ADDR_FIELD_W-1:0] address_o;
  logic [REG_IDX_W-1:0]    reg_index_o;
  logic                    to_memory_o;
  logic                    long_size_o;
  logic                    sign_extend_o;
  logic                    writeback_enable_o;
  logic [BASE_REG_W-1:0]   writeback_reg_o;
  logic                    last_o;

  move_request_t  pending_requests[$];
  transfer_item_t expected_transfers[$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  logic           req_accepted = 1'b0;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  int unsigned    stall_phase_left = 0;
  int unsigned    stall_style = 0;
  int unsigned    stall_tick = 0;

  register_list_transfer_sequencer_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mask_i             (mask_i),
    .is_long_i          (is_long_i),
    .to_regs_i          (to_regs_i),
    .mode_i             (mode_i),
    .base_reg_i         (base_reg_i),
    .base_address_i     (base_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .address_o          (address_o),
    .reg_index_o        (reg_index_o),
    .to_memory_o        (to_memory_o),
    .long_size_o        (long_size_o),
    .sign_extend_o      (sign_extend_o),
    .writeback_enable_o (writeback_enable_o),
    .writeback_reg_o    (writeback_reg_o),
    .last_o             (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic add_request(input logic [MASK_W-1:0] mask, input logic is_long,
                             input logic to_regs, input logic [1:0] mode,
                             input logic [BASE_REG_W-1:0] base_reg,
                             input logic [ADDR_FIELD_W-1:0] base_address,
                             input bit drain_first);
    move_request_t r;
    r.mask = mask;
    r.is_long = is_long;
    r.to_regs = to_regs;
    r.mode = mode;
    r.base_reg = base_reg;
    r.base_address = base_address;
    r.drain_first = drain_first;
    pending_requests.push_back(r);
  endtask

  task automatic expand_move_multiple(input move_request_t r);
    transfer_item_t t;
    logic [ADDR_FIELD_W-1:0] addr;
    logic [ADDR_FIELD_W-1:0] step;
    mode_e m;
    logic pre;
    logic post;
    m = mode_e'(r.mode);
    pre = (m == MODE_PREDEC);
    post = (m == MODE_POSTINC);
    step = r.is_long ? ADDR_FIELD_W'(STEP_LONG) : ADDR_FIELD_W'(STEP_WORD);
    addr = r.base_address;
    for (int idx = 0; idx < MASK_W; idx++) begin
      if (r.mask[idx]) begin
        t.kind = KIND_TRANSFER;
        t.long_size = r.is_long;
        t.writeback_enable = 1'b0;
        t.writeback_reg = '0;
        t.last = 1'b0;
        if (pre) begin
          addr = addr - step;
          t.address = addr;
          t.reg_index = REG_IDX_W'(15 - idx);
          t.to_memory = 1'b1;
          t.sign_extend = 1'b0;
        end else begin
          t.address = addr;
          t.reg_index = REG_IDX_W'(idx);
          t.to_memory = !r.to_regs;
          t.sign_extend = r.to_regs && !r.is_long;
          addr = addr + step;
        end
        expected_transfers.push_back(t);
      end
    end
    t.kind = KIND_FINISH;
    t.address = addr;
    t.reg_index = '0;
    t.to_memory = 1'b0;
    t.long_size = 1'b0;
    t.sign_extend = 1'b0;
    t.writeback_enable = pre || post;
    t.writeback_reg = r.base_reg;
    t.last = 1'b1;
    expected_transfers.push_back(t);
  endtask

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : watch_channels
    move_request_t  seen_req;
    transfer_item_t want;
    bit             ok;
    req_accepted <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen_req.mask = mask_i;
      seen_req.is_long = is_long_i;
      seen_req.to_regs = to_regs_i;
      seen_req.mode = mode_i;
      seen_req.base_reg = base_reg_i;
      seen_req.base_address = base_address_i;
      seen_req.drain_first = 1'b0;
      expand_move_multiple(seen_req);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_transfers.size() == 0) begin
        $display("%0t: unexpected item, expected none, got kind %0b address %0h",
                 $time, kind_o, address_o);
        error_count++;
      end else begin
        want = expected_transfers.pop_front();
        ok = 1'b1;
        ok &= field_ok("kind", 32'(want.kind), 32'(kind_o));
        ok &= field_ok("address", 32'(want.address), 32'(address_o));
        ok &= field_ok("reg_index", 32'(want.reg_index), 32'(reg_index_o));
        ok &= field_ok("to_memory", 32'(want.to_memory), 32'(to_memory_o));
        ok &= field_ok("long_size", 32'(want.long_size), 32'(long_size_o));
        ok &= field_ok("sign_extend", 32'(want.sign_extend), 32'(sign_extend_o));
        ok &= field_ok("writeback_enable", 32'(want.writeback_enable),
                       32'(writeback_enable_o));
        ok &= field_ok("writeback_reg", 32'(want.writeback_reg), 32'(writeback_reg_o));
        ok &= field_ok("last", 32'(want.last), 32'(last_o));
        if (!ok) begin
          error_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : drive_requests
    move_request_t nxt;
    if (rst_ni && (!in_valid_i || req_accepted)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain_first && expected_transfers.size() != 0)) begin
        nxt = pending_requests.pop_front();
        mask_i <= nxt.mask;
        is_long_i <= nxt.is_long;
        to_regs_i <= nxt.to_regs;
        mode_i <= nxt.mode;
        base_reg_i <= nxt.base_reg;
        base_address_i <= nxt.base_address;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 10);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_tick <= stall_tick + 1;
      if (stall_phase_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        stall_phase_left <= $urandom_range(20, 80);
        out_stall_i <= 1'b0;
      end else begin
        stall_phase_left <= stall_phase_left - 1;
        case (stall_style)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= stall_tick[1] & stall_tick[0];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [MASK_W-1:0]       mask;
    logic [1:0]              mode;
    logic [ADDR_FIELD_W-1:0] addr;
    int unsigned             pick;

    add_request(16'h0000, 1'b0, 1'b0, MODE_CONTROL, 3'd0, 24'h000000, 1'b0);
    add_request(16'h0000, 1'b1, 1'b1, MODE_POSTINC, 3'd7, 24'hFFFFFF, 1'b0);
    add_request(16'h0000, 1'b0, 1'b1, MODE_PREDEC, 3'd3, 24'h000000, 1'b0);
    add_request(16'hFFFF, 1'b1, 1'b1, MODE_CONTROL, 3'd1, 24'hFFFFF0, 1'b0);
    add_request(16'hFFFF, 1'b0, 1'b1, MODE_CONTROL, 3'd2, 24'h001000, 1'b0);
    add_request(16'hFFFF, 1'b0, 1'b0, MODE_POSTINC, 3'd4, 24'hFFFFFE, 1'b0);
    add_request(16'hFFFF, 1'b1, 1'b1, MODE_POSTINC, 3'd5, 24'h123456, 1'b0);
    add_request(16'hFFFF, 1'b1, 1'b1, MODE_PREDEC, 3'd7, 24'h000000, 1'b0);
    add_request(16'hFFFF, 1'b0, 1'b0, MODE_PREDEC, 3'd0, 24'h000010, 1'b0);
    add_request(16'h0001, 1'b1, 1'b0, MODE_PREDEC, 3'd6, 24'h800000, 1'b0);
    add_request(16'h8000, 1'b0, 1'b1, MODE_PREDEC, 3'd1, 24'h000002, 1'b0);
    add_request(16'h8000, 1'b1, 1'b1, MODE_CONTROL, 3'd2, 24'hABCDEF, 1'b0);
    add_request(16'h0001, 1'b0, 1'b1, MODE_POSTINC, 3'd3, 24'h7FFFFF, 1'b0);
    add_request(16'hAAAA, 1'b0, 1'b1, MODE_UNUSED, 3'd6, 24'h555554, 1'b0);
    add_request(16'h5555, 1'b1, 1'b0, MODE_UNUSED, 3'd5, 24'hFFFFF8, 1'b0);
    add_request(16'h00FF, 1'b0, 1'b1, MODE_POSTINC, 3'd2, 24'h0000FE, 1'b0);
    add_request(16'hFF00, 1'b1, 1'b0, MODE_PREDEC, 3'd4, 24'h000008, 1'b0);
    add_request(16'h0440, 1'b1, 1'b1, MODE_CONTROL, 3'd0, 24'h00A000, 1'b0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        mask = 16'h0000;
      end else if (pick == 1) begin
        mask = 16'hFFFF;
      end else if (pick <= 3) begin
        mask = 16'h0001 << $urandom_range(0, 15);
      end else begin
        mask = MASK_W'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        mode = MODE_CONTROL;
      end else if (pick <= 5) begin
        mode = MODE_POSTINC;
      end else if (pick <= 8) begin
        mode = MODE_PREDEC;
      end else begin
        mode = MODE_UNUSED;
      end
      if ($urandom_range(0, 3) == 0) begin
        addr = $urandom_range(0, 1) ? ADDR_FIELD_W'($urandom_range(0, 40))
                                    : 24'hFFFFFF - ADDR_FIELD_W'($urandom_range(0, 40));
      end else begin
        addr = ADDR_FIELD_W'($urandom);
      end
      add_request(mask, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), mode,
                  BASE_REG_W'($urandom_range(0, 7)), addr,
                  (n == 0) || (n == RANDOM_REQUESTS / 2));
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (expected_transfers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rlts_pkg.sv
rtl/rlts_front.sv
rtl/rlts_queue.sv
rtl/rlts_back.sv
rtl/register_list_transfer_sequencer_top.sv
dv/register_list_transfer_sequencer_top_tb.sv
